/* hw/rtl/aps_pkg.sv */
`timescale 1ns / 1ps
package aps_pkg;

  localparam int unsigned HeaderBytes = 5;
  localparam int unsigned NumChannels = 3;
  localparam int unsigned QueueDepth  = 2;

  // Input mode codes.
  localparam logic [2:0] MODE_START   = 3'd0;
  localparam logic [2:0] MODE_ACK     = 3'd1;
  localparam logic [2:0] MODE_TIMEOUT = 3'd2;
  localparam logic [2:0] MODE_FAIL    = 3'd3;
  localparam logic [2:0] MODE_CLEAR   = 3'd4;

  // Channel codes.
  localparam logic [1:0] CH_GENERAL = 2'd0;
  localparam logic [1:0] CH_VEHICLE = 2'd1;
  localparam logic [1:0] CH_CAN     = 2'd2;
  localparam logic [1:0] CH_INVALID = 2'd3;

  // Result kind codes.
  localparam logic [2:0] KIND_CTRL     = 3'd0;
  localparam logic [2:0] KIND_DATA     = 3'd1;
  localparam logic [2:0] KIND_BUSY     = 3'd2;
  localparam logic [2:0] KIND_COMPLETE = 3'd3;
  localparam logic [2:0] KIND_TIMEOUT  = 3'd4;
  localparam logic [2:0] KIND_FAIL     = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] REG_VEHICLE_CMD = 2'd0;
  localparam logic [1:0] REG_CAN_CMD     = 2'd1;

  typedef enum logic [2:0] {
    OP_START,
    OP_ACK,
    OP_TIMEOUT,
    OP_FAIL,
    OP_CLEAR
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [1:0]  ch;
    logic [15:0] command;
    logic [23:0] length;
    logic [31:0] address;
  } op_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  channel;
    logic [7:0]  transfer_id;
    logic [23:0] packet_offset;
    logic [23:0] frame_length;
    logic [39:0] header_word;
    logic [2:0]  header_first;
    logic [2:0]  header_count;
    logic [31:0] content_read_address;
    logic [12:0] content_count;
    logic [12:0] payload_length;
  } result_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage

/* hw/rtl/aps_front.sv */
`timescale 1ns / 1ps
module aps_front import aps_pkg::*; (
  input  logic        in_valid_i,
  input  logic [2:0]  mode_i,
  input  logic [1:0]  channel_i,
  input  logic [15:0] command_i,
  input  logic [23:0] length_i,
  input  logic [31:0] address_i,
  input  logic [15:0] vehicle_cmd_i,
  input  logic [15:0] can_cmd_i,
  output logic        push_o,
  output op_t         op_o
);

  logic [1:0] start_ch;

  // The vehicle channel wins when both codes match.
  always_comb begin
    if (command_i == vehicle_cmd_i) begin
      start_ch = CH_VEHICLE;
    end else if (command_i == can_cmd_i) begin
      start_ch = CH_CAN;
    end else begin
      start_ch = CH_GENERAL;
    end
  end

  always_comb begin
    op_o.command = command_i;
    op_o.length  = length_i;
    op_o.address = address_i;
    op_o.ch      = channel_i;
    op_o.op      = OP_CLEAR;
    push_o       = 1'b0;
    case (mode_i)
      MODE_START: begin
        op_o.op = OP_START;
        op_o.ch = start_ch;
        push_o  = in_valid_i;
      end
      MODE_ACK: begin
        op_o.op = OP_ACK;
        push_o  = in_valid_i && (channel_i != CH_INVALID);
      end
      MODE_TIMEOUT: begin
        op_o.op = OP_TIMEOUT;
        push_o  = in_valid_i && (channel_i != CH_INVALID);
      end
      MODE_FAIL: begin
        op_o.op = OP_FAIL;
        push_o  = in_valid_i && (channel_i != CH_INVALID);
      end
      MODE_CLEAR: begin
        // Reset all touches every channel, so the channel field is not carried.
        op_o.op = OP_CLEAR;
        op_o.ch = CH_GENERAL;
        push_o  = in_valid_i;
      end
      default: begin
        // Unknown modes are consumed and dropped here.
        push_o = 1'b0;
      end
    endcase
  end

endmodule

/* hw/rtl/aps_queue.sv */
`timescale 1ns / 1ps
module aps_queue import aps_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  op_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output op_t  op_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  op_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign op_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

/* hw/rtl/aps_back.sv */
`timescale 1ns / 1ps
module aps_back import aps_pkg::*; #(
  parameter int unsigned CHUNK_BYTES = 128
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    empty_i,
  input  op_t     op_i,
  output logic    pop_o,
  output hs_t     out_hs_o,
  input  logic    out_ready_i,
  output result_t result_o
);

  localparam logic [12:0] Chunk  = 13'(CHUNK_BYTES);
  localparam logic [2:0]  HdrLen = 3'(HeaderBytes);

  logic [7:0]  active_q   [NumChannels];
  logic [2:0]  hdr_left_q [NumChannels];
  logic [23:0] cnt_left_q [NumChannels];
  logic [23:0] offset_q   [NumChannels];
  logic [15:0] cmd_q      [NumChannels];
  logic [23:0] len_q      [NumChannels];
  logic [31:0] addr_q     [NumChannels];
  logic [7:0]  id_q, id_d, next_id;

  logic        out_valid_q, out_valid_d;
  result_t     result_q, result_d;
  logic        emit;

  logic [1:0]  ch;
  logic [7:0]  cur_id;
  logic [2:0]  hl, hcount, hfirst;
  logic [23:0] cl;
  logic [12:0] room, ccount;

  assign ch      = op_i.ch;
  assign pop_o   = !empty_i && (!out_valid_q || out_ready_i);
  assign next_id = (id_q == 8'hFF) ? 8'h01 : id_q + 8'h01;

  assign cur_id = active_q[ch];
  assign hl     = hdr_left_q[ch];
  assign cl     = cnt_left_q[ch];

  // Header bytes go out first, content fills the rest of the chunk.
  always_comb begin
    hcount = ({10'b0, hl} < Chunk) ? hl : Chunk[2:0];
    hfirst = (hcount != 3'd0) ? (HdrLen - hl) : 3'd0;
    room   = Chunk - {10'b0, hcount};
    if ((cl != 24'd0) && ({10'b0, hcount} < Chunk)) begin
      ccount = ({11'b0, room} > cl) ? cl[12:0] : room;
    end else begin
      ccount = 13'd0;
    end
  end

  always_comb begin
    emit     = 1'b0;
    id_d     = id_q;
    result_d = '0;
    result_d.channel     = ch;
    result_d.transfer_id = cur_id;
    if (pop_o) begin
      case (op_i.op)
        OP_START: begin
          emit = 1'b1;
          if (cur_id != 8'd0) begin
            result_d.kind = KIND_BUSY;
          end else begin
            id_d                  = next_id;
            result_d.kind         = KIND_CTRL;
            result_d.transfer_id  = next_id;
            result_d.frame_length = op_i.length + 24'(HeaderBytes);
          end
        end
        OP_ACK: begin
          if (cur_id != 8'd0) begin
            emit = 1'b1;
            if ((hl == 3'd0) && (cl == 24'd0)) begin
              result_d.kind = KIND_COMPLETE;
            end else begin
              result_d.kind                 = KIND_DATA;
              result_d.packet_offset        = offset_q[ch];
              result_d.header_word          = {cmd_q[ch], len_q[ch]};
              result_d.header_first         = hfirst;
              result_d.header_count         = hcount;
              result_d.content_read_address = (ccount != 13'd0) ? addr_q[ch] : 32'd0;
              result_d.content_count        = ccount;
              result_d.payload_length       = {10'b0, hcount} + ccount;
            end
          end
        end
        OP_TIMEOUT: begin
          emit          = (cur_id != 8'd0);
          result_d.kind = KIND_TIMEOUT;
        end
        OP_FAIL: begin
          emit          = (cur_id != 8'd0);
          result_d.kind = KIND_FAIL;
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      id_q        <= '0;
      for (int i = 0; i < NumChannels; i++) begin
        active_q[i]   <= '0;
        hdr_left_q[i] <= '0;
        cnt_left_q[i] <= '0;
        offset_q[i]   <= '0;
        cmd_q[i]      <= '0;
        len_q[i]      <= '0;
        addr_q[i]     <= '0;
      end
    end else begin
      out_valid_q <= out_valid_d;
      id_q        <= id_d;
      if (pop_o) begin
        case (op_i.op)
          OP_START: begin
            if (cur_id == 8'd0) begin
              active_q[ch]   <= next_id;
              hdr_left_q[ch] <= HdrLen;
              cnt_left_q[ch] <= op_i.length;
              offset_q[ch]   <= '0;
              cmd_q[ch]      <= op_i.command;
              len_q[ch]      <= op_i.length;
              addr_q[ch]     <= op_i.address;
            end
          end
          OP_ACK: begin
            if (cur_id != 8'd0) begin
              if ((hl == 3'd0) && (cl == 24'd0)) begin
                active_q[ch] <= '0;
              end else begin
                hdr_left_q[ch] <= hl - hcount;
                cnt_left_q[ch] <= cl - {11'b0, ccount};
                offset_q[ch]   <= offset_q[ch] + {21'b0, hcount} + {11'b0, ccount};
                addr_q[ch]     <= addr_q[ch] + {19'b0, ccount};
              end
            end
          end
          OP_TIMEOUT, OP_FAIL: begin
            active_q[ch] <= '0;
          end
          OP_CLEAR: begin
            for (int i = 0; i < NumChannels; i++) begin
              active_q[i] <= '0;
            end
          end
          default: begin
            active_q[ch] <= active_q[ch];
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      result_q <= result_d;
    end
  end

  assign out_hs_o.valid = out_valid_q;
  assign out_hs_o.ready = pop_o;
  assign result_o       = result_q;

endmodule

/* hw/rtl/ack_paced_message_segmenter_core.sv */
`timescale 1ns / 1ps
// Acknowledge-paced message segmenter with three transfer channels.
// Event words enter on the s_axis channel: tuser carries the mode (start,
// ack, timeout, send failed, reset all) and tdata the channel and message.
// Each word causes zero or one result word on the m_axis channel: tuser
// carries the result kind and tdata the descriptor fields.
// The cfg channel writes the two command codes that route a start to the
// vehicle information or CAN channel; it is always ready and should only
// be written while no event is in flight.
// A front stage classifies events and drops unknown modes and acks,
// timeouts and failures on the invalid channel; a two-entry queue
// feeds the back stage, which updates the channel state and loads the
// output register. One word is accepted per cycle while the queue is
// not full; the back stage stalls while the output register holds a
// result not yet taken.
// When the receiver stalls, the result holds in the output register, the
// queue fills and s_axis_tready falls once both entries are taken.
// Reset clears all channels, the id counter, the queue and both codes.
module ack_paced_message_segmenter_core import aps_pkg::*; #(
  parameter int unsigned CHUNK_BYTES = 128
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // channel[1:0], command[17:2], content_length[41:18], content_address[73:42]
  input  logic [79:0]  s_axis_tdata,
  // mode[2:0]
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_channel[1:0], transfer_id[9:2], packet_offset[33:10],
  // frame_length[57:34], header_word[97:58], header_first[100:98],
  // header_count[103:101], content_read_address[135:104],
  // content_count[148:136], payload_length[161:149]
  output logic [167:0] m_axis_tdata,
  // kind[2:0]
  output logic [2:0]   m_axis_tuser,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i
);

  logic [15:0] vehicle_cmd_q, can_cmd_q;
  logic        push, full, empty, pop;
  op_t         front_op, queue_op;
  hs_t         out_hs;
  result_t     res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vehicle_cmd_q <= '0;
      can_cmd_q     <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_VEHICLE_CMD: vehicle_cmd_q <= cfg_data_i;
        REG_CAN_CMD:     can_cmd_q     <= cfg_data_i;
        default: begin
          vehicle_cmd_q <= vehicle_cmd_q;
        end
      endcase
    end
  end

  assign s_axis_tready = !full;

  aps_front u_front (
    .in_valid_i    (s_axis_tvalid),
    .mode_i        (s_axis_tuser),
    .channel_i     (s_axis_tdata[1:0]),
    .command_i     (s_axis_tdata[17:2]),
    .length_i      (s_axis_tdata[41:18]),
    .address_i     (s_axis_tdata[73:42]),
    .vehicle_cmd_i (vehicle_cmd_q),
    .can_cmd_i     (can_cmd_q),
    .push_o        (push),
    .op_o          (front_op)
  );

  aps_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (front_op),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .op_o    (queue_op)
  );

  aps_back #(
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .op_i        (queue_op),
    .pop_o       (pop),
    .out_hs_o    (out_hs),
    .out_ready_i (m_axis_tready),
    .result_o    (res)
  );

  assign m_axis_tvalid = out_hs.valid;
  assign m_axis_tuser  = res.kind;
  assign m_axis_tdata  = {6'b0, res.payload_length, res.content_count,
                          res.content_read_address, res.header_count,
                          res.header_first, res.header_word, res.frame_length,
                          res.packet_offset, res.transfer_id, res.channel};

endmodule

/* dv/ack_paced_message_segmenter_core_tb.sv */
`timescale 1ns / 1ps
module ack_paced_message_segmenter_core_tb;
  import aps_pkg::*;

  localparam int unsigned ChunkBytes  = 128;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned HoldCycles  = 300;

  logic         clk_i;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [79:0]  s_axis_tdata  = '0;
  logic [2:0]   s_axis_tuser  = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [167:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;
  logic         cfg_valid_i   = 1'b0;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i   = '0;
  logic [15:0]  cfg_data_i    = '0;

  ack_paced_message_segmenter_core #(
    .CHUNK_BYTES(ChunkBytes)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Segmenter state as the testbench tracks it.
  logic [15:0] route_vehicle_cmd;
  logic [15:0] route_can_cmd;
  logic [7:0]  chan_id      [NumChannels];
  logic [2:0]  chan_hdr_left[NumChannels];
  logic [23:0] chan_body_left[NumChannels];
  logic [23:0] chan_offset  [NumChannels];
  logic [15:0] chan_cmd     [NumChannels];
  logic [23:0] chan_len     [NumChannels];
  logic [31:0] chan_addr    [NumChannels];
  logic [7:0]  last_transfer_id;

  result_t pending_results[$];

  bit          sender_paced   = 1'b1;
  bit          receiver_paced = 1'b1;
  int unsigned hold_request   = 0;

  int unsigned mismatches      = 0;
  int unsigned events_sent     = 0;
  int unsigned results_checked = 0;
  int unsigned data_checked    = 0;
  int unsigned busy_checked    = 0;
  int unsigned done_checked    = 0;
  int unsigned cancel_checked  = 0;
  int unsigned id_wraps        = 0;
  int unsigned code_settings   = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [23:0] pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 24'($urandom_range(0, 400));
    if (r < 90) return 24'($urandom_range(0, 3000));
    return 24'($urandom());
  endfunction

  // Prefers a channel that has a transfer in progress.
  function automatic logic [1:0] pick_channel();
    logic [1:0] live[$];
    for (int i = 0; i < NumChannels; i++) begin
      if (chan_id[i] != 8'd0) live.push_back(2'(i));
    end
    if (live.size() != 0 && $urandom_range(0, 9) < 9) begin
      return live[$urandom_range(0, live.size() - 1)];
    end
    return 2'($urandom_range(0, 2));
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < 40) $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    end
  endtask

  task automatic reset_segmenter_state();
    route_vehicle_cmd = '0;
    route_can_cmd     = '0;
    last_transfer_id  = '0;
    for (int i = 0; i < NumChannels; i++) begin
      chan_id[i]        = '0;
      chan_hdr_left[i]  = '0;
      chan_body_left[i] = '0;
      chan_offset[i]    = '0;
      chan_cmd[i]       = '0;
      chan_len[i]       = '0;
      chan_addr[i]      = '0;
    end
  endtask

  // Applies one event word to the tracked state and returns its result, if any.
  task automatic predict_segment(input logic [2:0] mode, input logic [1:0] ch,
                                 input logic [15:0] cmd, input logic [23:0] len,
                                 input logic [31:0] addr, output bit produced,
                                 output result_t res);
    logic [1:0]  c;
    logic [23:0] sent;
    logic [31:0] raddr;
    int unsigned hcount;
    int unsigned ccount;
    int unsigned room;
    res      = '0;
    produced = 1'b0;
    if (mode == MODE_START) begin
      if (cmd == route_vehicle_cmd) c = CH_VEHICLE;
      else if (cmd == route_can_cmd) c = CH_CAN;
      else c = CH_GENERAL;
      produced    = 1'b1;
      res.channel = c;
      if (chan_id[c] != 8'd0) begin
        res.kind        = KIND_BUSY;
        res.transfer_id = chan_id[c];
      end else begin
        if (last_transfer_id == 8'hFF) begin
          last_transfer_id = 8'd1;
          id_wraps++;
        end else begin
          last_transfer_id = last_transfer_id + 8'd1;
        end
        chan_id[c]        = last_transfer_id;
        chan_hdr_left[c]  = 3'(HeaderBytes);
        chan_body_left[c] = len;
        chan_offset[c]    = '0;
        chan_cmd[c]       = cmd;
        chan_len[c]       = len;
        chan_addr[c]      = addr;
        res.kind          = KIND_CTRL;
        res.transfer_id   = last_transfer_id;
        res.frame_length  = 24'(len + HeaderBytes);
      end
    end else if (mode == MODE_CLEAR) begin
      for (int i = 0; i < NumChannels; i++) chan_id[i] = '0;
    end else if (mode > MODE_CLEAR || ch == CH_INVALID || chan_id[ch] == 8'd0) begin
      produced = 1'b0;
    end else if (mode == MODE_TIMEOUT || mode == MODE_FAIL) begin
      produced        = 1'b1;
      res.kind        = (mode == MODE_TIMEOUT) ? KIND_TIMEOUT : KIND_FAIL;
      res.channel     = ch;
      res.transfer_id = chan_id[ch];
      chan_id[ch]     = '0;
    end else if (chan_hdr_left[ch] == 3'd0 && chan_body_left[ch] == 24'd0) begin
      produced        = 1'b1;
      res.kind        = KIND_COMPLETE;
      res.channel     = ch;
      res.transfer_id = chan_id[ch];
      chan_id[ch]     = '0;
    end else begin
      hcount = (chan_hdr_left[ch] < ChunkBytes) ? chan_hdr_left[ch] : ChunkBytes;
      ccount = 0;
      if (chan_body_left[ch] != 24'd0 && hcount < ChunkBytes) begin
        room   = ChunkBytes - hcount;
        ccount = (chan_body_left[ch] < room) ? chan_body_left[ch] : room;
      end
      sent  = chan_len[ch] - chan_body_left[ch];
      raddr = chan_addr[ch] + sent;
      produced                 = 1'b1;
      res.kind                 = KIND_DATA;
      res.channel              = ch;
      res.transfer_id          = chan_id[ch];
      res.packet_offset        = chan_offset[ch];
      res.header_word          = {chan_cmd[ch], chan_len[ch]};
      res.header_first         = (hcount != 0) ? 3'(HeaderBytes - chan_hdr_left[ch]) : 3'd0;
      res.header_count         = 3'(hcount);
      res.content_read_address = (ccount != 0) ? raddr : 32'd0;
      res.content_count        = 13'(ccount);
      res.payload_length       = 13'(hcount + ccount);
      chan_hdr_left[ch]  = chan_hdr_left[ch] - 3'(hcount);
      chan_body_left[ch] = chan_body_left[ch] - 24'(ccount);
      chan_offset[ch]    = 24'(chan_offset[ch] + hcount + ccount);
    end
  endtask

  // Offers one event word, waits for it to be taken, then records its result.
  task automatic send_event(input logic [2:0] mode, input logic [1:0] ch,
                            input logic [15:0] cmd, input logic [23:0] len,
                            input logic [31:0] addr);
    int unsigned gap;
    bit          produced;
    result_t     res;
    gap = sender_paced ? pick_gap() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {6'b0, addr, len, cmd, ch};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    events_sent++;
    predict_segment(mode, ch, cmd, len, addr, produced, res);
    if (produced) pending_results.push_back(res);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [1:0] index, input logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (index == REG_VEHICLE_CMD) route_vehicle_cmd = value;
    else if (index == REG_CAN_CMD) route_can_cmd = value;
    @(posedge clk_i);
  endtask

  task automatic set_route_codes(input logic [15:0] vehicle_cmd, input logic [15:0] can_cmd);
    wait_drained();
    write_register(REG_VEHICLE_CMD, vehicle_cmd);
    write_register(REG_CAN_CMD, can_cmd);
    code_settings++;
  endtask

  // Mostly well-formed traffic: starts followed by acks on live channels, with
  // cancels, resets and ignored words mixed in.
  task automatic random_event();
    int unsigned r;
    logic [15:0] cmd;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      if ($urandom_range(0, 1) == 0) begin
        send_event(3'($urandom_range(5, 7)), 2'($urandom()), 16'($urandom()),
                   24'($urandom()), $urandom());
      end else begin
        send_event(3'($urandom_range(MODE_ACK, MODE_FAIL)), CH_INVALID, 16'($urandom()),
                   24'($urandom()), $urandom());
      end
    end else if (r < 8) begin
      send_event(MODE_CLEAR, 2'($urandom()), 16'($urandom()), 24'($urandom()), $urandom());
    end else if (r < 30) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: cmd = route_vehicle_cmd;
        4, 5, 6:    cmd = route_can_cmd;
        default:    cmd = 16'($urandom());
      endcase
      send_event(MODE_START, 2'($urandom()), cmd, pick_length(), $urandom());
    end else if (r < 37) begin
      send_event(MODE_TIMEOUT, pick_channel(), 16'($urandom()), 24'($urandom()),
                 $urandom());
    end else if (r < 43) begin
      send_event(MODE_FAIL, pick_channel(), 16'($urandom()), 24'($urandom()), $urandom());
    end else begin
      send_event(MODE_ACK, pick_channel(), 16'($urandom()), 24'($urandom()), $urandom());
    end
  endtask

  // With both codes at reset value, command zero goes to the vehicle channel.
  task automatic test_default_routing();
    send_event(MODE_START, CH_GENERAL, 16'h0000, 24'd10, 32'h0000_1000);
    send_event(MODE_START, CH_CAN, 16'h0000, 24'd20, 32'h0000_2000);
    send_event(MODE_START, CH_VEHICLE, 16'h0005, 24'd0, 32'h0);
    send_event(MODE_TIMEOUT, CH_VEHICLE, '0, '0, '0);
    send_event(MODE_TIMEOUT, CH_GENERAL, '0, '0, '0);
  endtask

  task automatic test_directed_transfers();
    set_route_codes(16'h1234, 16'hABCD);
    // Empty content: header only, then completion, then an ack with nothing active.
    send_event(MODE_START, CH_INVALID, 16'hFFFF, 24'd0, 32'hFFFF_FFFF);
    send_event(MODE_ACK, CH_GENERAL, '0, '0, '0);
    send_event(MODE_ACK, CH_GENERAL, '0, '0, '0);
    send_event(MODE_ACK, CH_GENERAL, '0, '0, '0);
    // Two data words whose content address wraps past the top of memory.
    send_event(MODE_START, CH_GENERAL, 16'h1234, 24'd250, 32'hFFFF_FF80);
    send_event(MODE_ACK, CH_VEHICLE, '0, '0, '0);
    send_event(MODE_ACK, CH_VEHICLE, '0, '0, '0);
    send_event(MODE_ACK, CH_VEHICLE, '0, '0, '0);
    // Longest length: the total wraps, a second start reports busy.
    send_event(MODE_START, CH_GENERAL, 16'hABCD, 24'hFF_FFFF, 32'h0);
    send_event(MODE_ACK, CH_CAN, '1, '1, '1);
    send_event(MODE_ACK, CH_CAN, '0, '0, '0);
    send_event(MODE_START, CH_GENERAL, 16'hABCD, 24'd7, 32'h1);
    send_event(MODE_TIMEOUT, CH_CAN, '0, '0, '0);
    send_event(MODE_START, CH_CAN, 16'h0000, 24'hFF_FFFA, 32'h5555_AAAA);
    send_event(MODE_ACK, CH_GENERAL, '0, '0, '0);
    send_event(MODE_FAIL, CH_GENERAL, '0, '0, '0);
    // Words that cause nothing.
    send_event(MODE_ACK, CH_INVALID, '1, '1, '1);
    send_event(MODE_TIMEOUT, CH_INVALID, '0, '0, '0);
    send_event(MODE_FAIL, CH_VEHICLE, '0, '0, '0);
    send_event(3'd5, CH_GENERAL, '1, '1, '1);
    send_event(3'd6, CH_VEHICLE, '0, '0, '0);
    send_event(3'd7, CH_CAN, '1, '0, '1);
    // Reset all keeps the id counter but drops the transfer.
    send_event(MODE_START, CH_GENERAL, 16'h1234, 24'd3, 32'h10);
    send_event(MODE_CLEAR, CH_GENERAL, '0, '0, '0);
    send_event(MODE_ACK, CH_VEHICLE, '0, '0, '0);
  endtask

  // Keeps taking ids on all channels until the counter wraps past 255.
  task automatic test_id_wrap();
    set_route_codes(16'($urandom()), 16'($urandom()));
    while (id_wraps == 0 || last_transfer_id < 8'd4) begin
      send_event(MODE_START, 2'($urandom()), route_vehicle_cmd, pick_length(), $urandom());
      send_event(MODE_START, 2'($urandom()), route_can_cmd, pick_length(), $urandom());
      send_event(MODE_START, 2'($urandom()), 16'($urandom()), pick_length(), $urandom());
      send_event(MODE_CLEAR, 2'($urandom()), 16'($urandom()), 24'($urandom()), $urandom());
    end
  endtask

  // The receiver holds off long enough for the queue to fill and stall input.
  task automatic test_backpressure();
    set_route_codes(16'h00FF, 16'hFF00);
    hold_request = HoldCycles;
    repeat (40) random_event();
    wait_drained();
  endtask

  task automatic test_random_phases();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       set_route_codes(16'hFFFF, 16'hFFFF);
        1:       set_route_codes(16'hFFFF, 16'h0000);
        2:       set_route_codes(16'h0000, 16'hFFFF);
        default: set_route_codes(16'($urandom()), 16'($urandom()));
      endcase
      sender_paced   = (phase != 2);
      receiver_paced = (phase != 2);
      repeat (150) random_event();
    end
    sender_paced   = 1'b1;
    receiver_paced = 1'b1;
  endtask

  initial begin
    reset_segmenter_state();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_routing();
    test_directed_transfers();
    test_id_wrap();
    test_backpressure();
    test_random_phases();
    wait_drained();
    $display("Sent %0d event words; checked %0d results (%0d data, %0d busy, %0d complete,",
             events_sent, results_checked, data_checked, busy_checked, done_checked);
    $display("%0d cancelled) over %0d command settings with %0d id wraps.",
             cancel_checked, code_settings, id_wraps);
    if (mismatches == 0) begin
      $display("ack_paced_message_segmenter_core regression: pass");
    end else begin
      $display("ack_paced_message_segmenter_core regression: fail");
    end
    $finish;
  end

  // Result sink: random short stalls, the occasional long one, and any hold-off
  // a test asks for.
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end else if (stall_left == 0 && receiver_paced) begin
        stall_left = pick_gap();
      end
      if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : result_checker
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind                 = m_axis_tuser;
      got.channel              = m_axis_tdata[1:0];
      got.transfer_id          = m_axis_tdata[9:2];
      got.packet_offset        = m_axis_tdata[33:10];
      got.frame_length         = m_axis_tdata[57:34];
      got.header_word          = m_axis_tdata[97:58];
      got.header_first         = m_axis_tdata[100:98];
      got.header_count         = m_axis_tdata[103:101];
      got.content_read_address = m_axis_tdata[135:104];
      got.content_count        = m_axis_tdata[148:136];
      got.payload_length       = m_axis_tdata[161:149];
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result word of kind %0d with nothing outstanding",
                                  got.kind));
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        case (want.kind)
          KIND_DATA:                data_checked++;
          KIND_BUSY:                busy_checked++;
          KIND_COMPLETE:            done_checked++;
          KIND_TIMEOUT, KIND_FAIL:  cancel_checked++;
          default: ;
        endcase
        check_field("kind", 64'(got.kind), 64'(want.kind));
        check_field("out_channel", 64'(got.channel), 64'(want.channel));
        check_field("transfer_id", 64'(got.transfer_id), 64'(want.transfer_id));
        check_field("packet_offset", 64'(got.packet_offset), 64'(want.packet_offset));
        check_field("frame_length", 64'(got.frame_length), 64'(want.frame_length));
        check_field("header_word", 64'(got.header_word), 64'(want.header_word));
        check_field("header_first", 64'(got.header_first), 64'(want.header_first));
        check_field("header_count", 64'(got.header_count), 64'(want.header_count));
        check_field("content_read_address", 64'(got.content_read_address),
                    64'(want.content_read_address));
        check_field("content_count", 64'(got.content_count), 64'(want.content_count));
        check_field("payload_length", 64'(got.payload_length), 64'(want.payload_length));
      end
    end
  end

  // Ends the run if no word moves on any channel for too long.
  always @(posedge clk_i) begin : watchdog
    int unsigned quiet;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= StallLimit) begin
      $display("Stalled: no word moved for %0d cycles, %0d results outstanding.",
               quiet, pending_results.size());
      $display("ack_paced_message_segmenter_core regression: fail");
      $finish;
    end
  end

endmodule

/* filelist.f */
hw/rtl/aps_pkg.sv
hw/rtl/aps_front.sv
hw/rtl/aps_queue.sv
hw/rtl/aps_back.sv
hw/rtl/ack_paced_message_segmenter_core.sv
dv/ack_paced_message_segmenter_core_tb.sv
